@@ rtl/core/jos_pkg.sv @@
// ----------------------------------------------------------------------------
// jos_pkg
// Shared types and constants for the elimination order block.
// ----------------------------------------------------------------------------
package jos_pkg;

   localparam int MAX_PEOPLE = 64;
   localparam int IDX_W      = $clog2(MAX_PEOPLE);
   localparam int CNT_W      = $clog2(MAX_PEOPLE + 1);
   localparam int SIZE_W     = 7;
   localparam int STEP_W     = 8;
   localparam int BIT_W      = $clog2(STEP_W);

   typedef struct packed {
      logic [SIZE_W-1:0] circle_size;
      logic [STEP_W-1:0] step_count;
   } req_item_type;

   typedef struct packed {
      logic [SIZE_W-1:0] person;
      logic              last;
   } rsp_item_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PREP,
      ST_DIV,
      ST_WALK
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic div_init;
      logic div_step;
      logic walk_step;
      logic remove;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic empty;
      logic div_done;
      logic hit;
   } status_type;

endpackage

@@ rtl/core/jos_ctrl.sv @@
// ----------------------------------------------------------------------------
// jos_ctrl
// Sequencer: remainder, bitmap walk and removal, once per person.
// ----------------------------------------------------------------------------
module jos_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   output jos_pkg::cmd_type    cmd,
   input  jos_pkg::status_type status
);
   import jos_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      busy     = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            if (status.empty) begin
               state_in = ST_IDLE;
            end else begin
               cmd.div_init = 1'b1;
               state_in     = ST_DIV;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_done) begin
               state_in = ST_WALK;
            end
         end
         ST_WALK: begin
            if (status.hit) begin
               cmd.remove = 1'b1;
               state_in   = ST_PREP;
            end else begin
               cmd.walk_step = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

@@ rtl/core/jos_dpath.sv @@
// ----------------------------------------------------------------------------
// jos_dpath
// Alive bitmap, walk pointer, bit-serial remainder and result register.
// ----------------------------------------------------------------------------
module jos_dpath (
   input  logic                 clock,
   input  logic                 reset,
   input  jos_pkg::req_item_type req_item,
   input  jos_pkg::cmd_type     cmd,
   output jos_pkg::status_type  status,
   output logic                 rsp_strobe,
   output jos_pkg::rsp_item_type rsp_item
);
   import jos_pkg::*;

   logic [CNT_W-1:0]      n_ff, n_in;
   logic [STEP_W-1:0]     km1_ff, km1_in;
   logic [MAX_PEOPLE-1:0] alive_ff, alive_in;
   logic [IDX_W-1:0]      cur_ff, cur_in;
   logic [CNT_W-1:0]      living_ff, living_in;
   logic [STEP_W-1:0]     rem_ff, rem_in;
   logic [BIT_W-1:0]      bit_ff, bit_in;
   rsp_item_type          rsp_ff, rsp_in;
   logic                  strobe_ff, strobe_in;

   logic [CNT_W-1:0]      n_sat;
   logic [STEP_W-1:0]     rem_sh;
   logic [CNT_W-1:0]      cur_plus;
   logic [IDX_W-1:0]      cur_next;

   // clamp size, zero step behaves as one
   always_comb begin
      if (req_item.circle_size > SIZE_W'(MAX_PEOPLE)) begin
         n_sat = CNT_W'(MAX_PEOPLE);
      end else begin
         n_sat = CNT_W'(req_item.circle_size);
      end
   end

   assign rem_sh   = {rem_ff[STEP_W-2:0], km1_ff[bit_ff]};
   assign cur_plus = CNT_W'(cur_ff) + CNT_W'(1);
   assign cur_next = (cur_plus == n_ff) ? '0 : cur_plus[IDX_W-1:0];

   assign status.empty    = (living_ff == '0);
   assign status.div_done = (bit_ff == '0);
   assign status.hit      = alive_ff[cur_ff] && (rem_ff == '0);

   always_comb begin
      n_in      = n_ff;
      km1_in    = km1_ff;
      alive_in  = alive_ff;
      cur_in    = cur_ff;
      living_in = living_ff;
      rem_in    = rem_ff;
      bit_in    = bit_ff;
      rsp_in    = rsp_ff;
      strobe_in = 1'b0;

      if (cmd.load) begin
         n_in      = n_sat;
         living_in = n_sat;
         km1_in    = (req_item.step_count == '0) ? '0 : req_item.step_count - STEP_W'(1);
         cur_in    = '0;
         for (int i = 0; i < MAX_PEOPLE; i++) begin
            alive_in[i] = (CNT_W'(i) < n_sat);
         end
      end

      if (cmd.div_init) begin
         rem_in = '0;
         bit_in = BIT_W'(STEP_W - 1);
      end

      // restoring division, one dividend bit a cycle
      if (cmd.div_step) begin
         if (rem_sh >= STEP_W'(living_ff)) begin
            rem_in = rem_sh - STEP_W'(living_ff);
         end else begin
            rem_in = rem_sh;
         end
         bit_in = bit_ff - BIT_W'(1);
      end

      if (cmd.walk_step) begin
         if (alive_ff[cur_ff]) begin
            rem_in = rem_ff - STEP_W'(1);
         end
         cur_in = cur_next;
      end

      if (cmd.remove) begin
         alive_in[cur_ff] = 1'b0;
         living_in        = living_ff - CNT_W'(1);
         rsp_in.person    = SIZE_W'(cur_ff) + SIZE_W'(1);
         rsp_in.last      = (living_ff == CNT_W'(1));
         strobe_in        = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         living_ff <= '0;
         bit_ff    <= '0;
         strobe_ff <= 1'b0;
      end else begin
         living_ff <= living_in;
         bit_ff    <= bit_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff     <= n_in;
      km1_ff   <= km1_in;
      alive_ff <= alive_in;
      cur_ff   <= cur_in;
      rem_ff   <= rem_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_item   = rsp_ff;

endmodule

@@ rtl/core/josephus_elimination_order.sv @@
// ----------------------------------------------------------------------------
// josephus_elimination_order
// Emits the removal order of a circle of people, every k-th one removed.
// ----------------------------------------------------------------------------
// Usage:
//  - A transaction is taken on req_item when start is high and busy is low.
//    circle_size above MAX_PEOPLE is clamped; step_count 0 acts as 1.
//  - busy stays high until the last result has gone out; a new transaction
//    can be taken in the cycle after the final strobe.
//  - Each removal leaves as one rsp_item transaction, marked by a one-cycle
//    rsp_strobe. The receiver cannot stall, so no back-pressure exists.
//    rsp_item.last flags the final removal. circle_size 0 gives no results.
//  - Per removal: a set-up step (ST_PREP), the bit-serial remainder of
//    (k-1) by the living count, then one bitmap slot per cycle until the
//    target (at most about one lap of circle_size slots), then the removal.
//    The walk over the alive bitmap, one slot a cycle, dominates a run.
//  - Reset (synchronous, active high) returns the sequencer to idle and
//    drops any run in progress; no result is emitted for it.
// ----------------------------------------------------------------------------
module josephus_elimination_order (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  jos_pkg::req_item_type req_item,
   output logic                  rsp_strobe,
   output jos_pkg::rsp_item_type rsp_item
);
   import jos_pkg::*;

   cmd_type    cmd;
   status_type status;

   // sequencer
   jos_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .cmd    (cmd),
      .status (status)
   );

   // bitmap, remainder unit and result register
   jos_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .req_item   (req_item),
      .cmd        (cmd),
      .status     (status),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

   // results only come out during a run
   a_strobe_busy : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> busy)
      else $error("result strobe outside a run");

   // a run never answers in the cycle after it is taken
   a_no_early : assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy && !rsp_strobe))
      else $error("run did not start correctly");

   // the final removal ends the run
   a_last_ends : assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_item.last) |=> (!busy && !rsp_strobe))
      else $error("activity after final removal");

   // a result strobe is never directly followed by another
   a_spacing : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("back-to-back results");

endmodule
